@@ sv/fxalu_pkg.sv @@
// -----------------------------------------------------------------------------
// fxalu_pkg: shared definitions for the Q24.8 fixed-point ALU
// Opcode codes, port field widths and the saturation helper.
// -----------------------------------------------------------------------------
package fxalu_pkg;

  localparam int OpW   = 4;
  localparam int DataW = 32;

  localparam logic [OpW-1:0] OP_ADD      = 4'd0;
  localparam logic [OpW-1:0] OP_SUB      = 4'd1;
  localparam logic [OpW-1:0] OP_MUL      = 4'd2;
  localparam logic [OpW-1:0] OP_DIV      = 4'd3;
  localparam logic [OpW-1:0] OP_MIN      = 4'd4;
  localparam logic [OpW-1:0] OP_MAX      = 4'd5;
  localparam logic [OpW-1:0] OP_INC      = 4'd6;
  localparam logic [OpW-1:0] OP_DEC      = 4'd7;
  localparam logic [OpW-1:0] OP_FROM_INT = 4'd8;
  localparam logic [OpW-1:0] OP_TO_INT   = 4'd9;

  // Bit positions of the result fields inside m_tdata.
  localparam int OutLessBit   = 32;
  localparam int OutEqualBit  = 33;
  localparam int OutGreatBit  = 34;
  localparam int OutOvfBit    = 35;
  localparam int OutDzBit     = 36;
  localparam int OutTdataW    = 40;
  localparam int InTdataW     = 64;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic             ovf;
  } sat_t;

  // Applies a sign to a magnitude and clamps it to the signed 32-bit range.
  function automatic sat_t sat_mag(input logic [63:0] m, input logic neg);
    sat_t r;
    r.ovf   = 1'b0;
    r.value = '0;
    if (neg) begin
      if (m > 64'h0000_0000_8000_0000) begin
        r.ovf   = 1'b1;
        r.value = 32'h8000_0000;
      end else begin
        r.value = 32'(-m[31:0]);
      end
    end else begin
      if (m > 64'h0000_0000_7FFF_FFFF) begin
        r.ovf   = 1'b1;
        r.value = 32'h7FFF_FFFF;
      end else begin
        r.value = m[31:0];
      end
    end
    return r;
  endfunction

endpackage

@@ sv/fixed_point_q24_8_alu.sv @@
// -----------------------------------------------------------------------------
// fixed_point_q24_8_alu: pipelined signed fixed-point ALU
// Add, subtract, exact rounded multiply and divide, min, max and conversions.
// -----------------------------------------------------------------------------
// Every item takes the same path through the pipeline; while the output is
// taken one item can enter on every clock, so throughput is one item per
// cycle. On its way to the output an item (Q24.8 by default) passes one input
// register, one stage that forms magnitudes, flags and the 32x32 product,
// one restoring-division step per quotient bit (FRACTION_BITS + 33 of them,
// set by the width of the doubled dividend), and the output register where
// rounding and saturation are finished. The opcode rides on s_tuser. When the
// output is not taken the whole pipeline holds, so no item is lost or doubled.
// Multiply and divide round to nearest with ties away from zero and clamp to
// the signed 32-bit range with the overflow flag set. A zero divisor sets
// divide_by_zero and returns full scale with the sign of operand_a, or zero.
// Add, subtract, increment, decrement and from_int wrap. Unused opcodes give
// a zero result; the compare flags are always valid.
module fixed_point_q24_8_alu #(
  parameter int FRACTION_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // Fields from bit 0: operand_a[31:0], operand_b[63:32].
  input  logic [63:0] s_tdata,
  // Fields from bit 0: opcode[3:0].
  input  logic [3:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // Fields from bit 0: result_value[31:0], a_less[32], a_equal[33],
  // a_greater[34], overflow[35], divide_by_zero[36], zero fill[39:37].
  output logic [39:0] m_tdata
);

  // Quotient bits of floor(2 * |a| * 2^F / |b|).
  localparam int DW = 33 + FRACTION_BITS;
  // Stage 1 is the prep stage; stages 2 .. NS-1 are division steps.
  localparam int NS = DW + 2;

  typedef struct packed {
    logic [3:0]        op;
    logic              neg;
    logic              lt;
    logic              eq;
    logic              gt;
    logic              dz;
    logic [31:0]       simple;
    logic [63:0]       prod;
    logic [31:0]       dsr;
    logic [31:0]       rem;
    logic [DW-1:0]     dvd;
    logic [DW-1:0]     quo;
  } stage_t;

  logic              en;
  logic [NS-1:0]     vld;
  logic [3:0]        in_op;
  logic [31:0]       in_a;
  logic [31:0]       in_b;
  stage_t            pl      [1:NS-1];
  stage_t            pl_next [1:NS-1];

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  function automatic stage_t div_step(input stage_t s);
    stage_t     r;
    logic [32:0] sh;
    logic        take;
    r    = s;
    sh   = {s.rem, s.dvd[DW-1]};
    take = (sh >= {1'b0, s.dsr});
    r.rem = take ? 32'(sh - {1'b0, s.dsr}) : sh[31:0];
    r.dvd = {s.dvd[DW-2:0], 1'b0};
    r.quo = {s.quo[DW-2:0], take};
    return r;
  endfunction

  // Prep stage: magnitudes, compare flags, the full product and every
  // result that needs neither the product nor the quotient.
  always_comb begin
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic        a_neg;
    logic        b_neg;
    stage_t      p;
    a_neg    = in_a[31];
    b_neg    = in_b[31];
    mag_a    = a_neg ? 32'(-in_a) : in_a;
    mag_b    = b_neg ? 32'(-in_b) : in_b;
    p.op     = in_op;
    p.neg    = a_neg ^ b_neg;
    p.lt     = $signed(in_a) <  $signed(in_b);
    p.eq     = in_a == in_b;
    p.gt     = $signed(in_a) >  $signed(in_b);
    p.dz     = (in_op == fxalu_pkg::OP_DIV) && (in_b == '0);
    p.prod   = 64'(mag_a) * 64'(mag_b);
    p.dsr    = mag_b;
    p.rem    = '0;
    p.dvd    = {mag_a, {(FRACTION_BITS + 1){1'b0}}};
    p.quo    = '0;
    case (in_op)
      fxalu_pkg::OP_ADD:      p.simple = in_a + in_b;
      fxalu_pkg::OP_SUB:      p.simple = in_a - in_b;
      fxalu_pkg::OP_MIN:      p.simple = p.lt ? in_a : in_b;
      fxalu_pkg::OP_MAX:      p.simple = p.gt ? in_a : in_b;
      fxalu_pkg::OP_INC:      p.simple = in_a + 32'd1;
      fxalu_pkg::OP_DEC:      p.simple = in_a - 32'd1;
      fxalu_pkg::OP_FROM_INT: p.simple = in_a << FRACTION_BITS;
      fxalu_pkg::OP_TO_INT:   p.simple = 32'($signed(in_a) >>> FRACTION_BITS);
      // Zero divisor answer: full scale toward the sign of the dividend.
      fxalu_pkg::OP_DIV: begin
        if (a_neg)               p.simple = 32'h8000_0000;
        else if (in_a != '0)     p.simple = 32'h7FFF_FFFF;
        else                     p.simple = '0;
      end
      default:                p.simple = '0;
    endcase
    pl_next[1] = p;
  end

  for (genvar gk = 2; gk < NS; gk++) begin : g_div
    always_comb pl_next[gk] = div_step(pl[gk-1]);
  end

  // Final rounding, saturation and result select into the output register.
  logic [63:0]     mul_rnd;
  logic [DW:0]     quo_rnd;
  fxalu_pkg::sat_t mul_sat;
  fxalu_pkg::sat_t div_sat;
  logic [39:0]     out_next;

  always_comb begin
    stage_t f;
    f       = pl[NS-1];
    mul_rnd = (f.prod + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
    quo_rnd = ({1'b0, f.quo} + (DW + 1)'(1)) >> 1;
    mul_sat = fxalu_pkg::sat_mag(mul_rnd, f.neg);
    div_sat = fxalu_pkg::sat_mag(64'(quo_rnd), f.neg);
    out_next = '0;
    out_next[fxalu_pkg::OutLessBit]  = f.lt;
    out_next[fxalu_pkg::OutEqualBit] = f.eq;
    out_next[fxalu_pkg::OutGreatBit] = f.gt;
    out_next[fxalu_pkg::OutDzBit]    = f.dz;
    if (f.op == fxalu_pkg::OP_MUL) begin
      out_next[31:0]                 = mul_sat.value;
      out_next[fxalu_pkg::OutOvfBit] = mul_sat.ovf;
    end else if (f.op == fxalu_pkg::OP_DIV && !f.dz) begin
      out_next[31:0]                 = div_sat.value;
      out_next[fxalu_pkg::OutOvfBit] = div_sat.ovf;
    end else begin
      out_next[31:0]                 = f.simple;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vld      <= {vld[NS-2:0], s_tvalid};
      m_tvalid <= vld[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_op   <= s_tuser;
      in_a    <= s_tdata[31:0];
      in_b    <= s_tdata[63:32];
      for (int i = 1; i < NS; i++) begin
        pl[i] <= pl_next[i];
      end
      m_tdata <= out_next;
    end
  end

endmodule

@@ sv/fxalu_checker.sv @@
// -----------------------------------------------------------------------------
// fxalu_checker: port-level checks for the fixed-point ALU
// Watches the stream ports and flags inconsistent result items.
// -----------------------------------------------------------------------------
module fxalu_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // A held result keeps its value until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result item changed while stalled");

  // Exactly one compare flag is set on every result.
  a_cmp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot(m_tdata[fxalu_pkg::OutGreatBit:fxalu_pkg::OutLessBit]))
    else $error("compare flags not one-hot");

  // A zero divisor never reports saturation as well.
  a_dz: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[fxalu_pkg::OutDzBit] && m_tdata[fxalu_pkg::OutOvfBit]))
    else $error("divide_by_zero together with overflow");

  // The input side only stalls while the output is held.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output back-pressure");

  // No result appears in the cycle after reset.
  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind fixed_point_q24_8_alu fxalu_checker u_fxalu_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
